/* src/cesc_pkg.sv */
// ----------------------------------------------------------------------------
// cesc_pkg: shared definitions for the calculator expression syntax checker
// Character codes, the function-name table, the transaction type and the
// letter-run judging function.
// ----------------------------------------------------------------------------
`default_nettype none

package cesc_pkg;

  // Deepest parenthesis nesting that is still legal.
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  typedef logic [7:0]         cesc_char_t;
  typedef logic [DEPTH_W-1:0] cesc_depth_t;
  typedef cesc_char_t         cesc_word_t [4];

  // One input transaction as it travels from the input register to the core.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } cesc_item_t;

  localparam cesc_char_t CH_LPAREN = 8'h28;
  localparam cesc_char_t CH_RPAREN = 8'h29;
  localparam cesc_char_t CH_STAR   = 8'h2A;
  localparam cesc_char_t CH_PLUS   = 8'h2B;
  localparam cesc_char_t CH_MINUS  = 8'h2D;
  localparam cesc_char_t CH_POINT  = 8'h2E;
  localparam cesc_char_t CH_SLASH  = 8'h2F;
  localparam cesc_char_t CH_CARET  = 8'h5E;
  localparam cesc_char_t CH_NUL    = 8'h00;

  localparam int NUM_FUNCS = 9;

  // Function names that must be followed directly by an opening parenthesis.
  localparam cesc_word_t FUNC_NAMES [NUM_FUNCS] = '{
    '{"c", "o", "s", CH_NUL},
    '{"s", "i", "n", CH_NUL},
    '{"t", "a", "n", CH_NUL},
    '{"a", "c", "o", "s"},
    '{"a", "s", "i", "n"},
    '{"a", "t", "a", "n"},
    '{"s", "q", "r", "t"},
    '{"l", "n", CH_NUL, CH_NUL},
    '{"l", "o", "g", CH_NUL}
  };
  localparam logic [2:0] FUNC_LENS [NUM_FUNCS] = '{
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3
  };

  function automatic logic is_op_char(input cesc_char_t c);
    return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) ||
           (c == CH_MINUS) || (c == CH_CARET);
  endfunction

  function automatic logic is_letter(input cesc_char_t c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input cesc_char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Judges a finished letter run. Only the first len letters are looked at.
  function automatic logic word_ok(input cesc_word_t letters,
                                   input logic [2:0] len,
                                   input logic       has_next,
                                   input cesc_char_t follower);
    logic ok;
    logic same;
    ok = 1'b0;
    if ((len == 3'd1) && (letters[0] == "x")) begin
      ok = 1'b1;
    end else if ((len == 3'd3) && (letters[0] == "m") && (letters[1] == "o") &&
                 (letters[2] == "d")) begin
      ok = 1'b1;
    end else if (has_next && (follower == CH_LPAREN) && (len <= 3'd4)) begin
      for (int f = 0; f < NUM_FUNCS; f++) begin
        same = (FUNC_LENS[f] == len);
        for (int k = 0; k < 4; k++) begin
          if ((k < int'(len)) && (FUNC_NAMES[f][k] != letters[k])) begin
            same = 1'b0;
          end
        end
        if (same) begin
          ok = 1'b1;
        end
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

/* src/cesc_in_stage.sv */
// ----------------------------------------------------------------------------
// cesc_in_stage: input register
// Captures one character transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cesc_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cesc_pkg::cesc_item_t in_item,
  output logic                    item_valid,
  input  wire logic               item_take,
  output cesc_pkg::cesc_item_t    item
);
  import cesc_pkg::*;

  logic       valid_r;
  cesc_item_t item_r;

  // The register may refill in the same cycle that the core takes its content.
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* src/cesc_core.sv */
// ----------------------------------------------------------------------------
// cesc_core: checking state and result register
// Updates the running parenthesis, operator, letter-run and number checks for
// each character and registers the verdict when the last character arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module cesc_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  output logic                      item_take,
  input  wire cesc_pkg::cesc_item_t item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_verdict
);
  import cesc_pkg::*;

  typedef enum logic [1:0] {
    NUM_OUTSIDE,
    NUM_INT,
    NUM_POINT,
    NUM_FRAC
  } num_phase_t;

  cesc_depth_t depth_r,     depth_nxt;
  logic        prev_op_r,   prev_op_nxt;
  cesc_word_t  word_r;
  cesc_word_t  word_cur;
  logic [2:0]  word_len_r,  word_len_nxt;
  num_phase_t  phase_r,     phase_nxt;
  logic        fault_r,     fault_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        verdict_r,   verdict_nxt;
  logic        word_wr;
  logic        final_fault;

  cesc_char_t c;
  logic       op;
  logic       alpha;
  logic       digit;

  assign c     = item.char_code;
  assign op    = is_op_char(c);
  assign alpha = is_letter(c);
  assign digit = is_digit(c);

  // Ordinary characters never stall; the last one waits for a free result slot.
  assign item_take = item_valid && (!item.last_char || !out_valid_r || out_ready);

  always_comb begin
    depth_nxt    = depth_r;
    prev_op_nxt  = op;
    word_len_nxt = word_len_r;
    word_wr      = 1'b0;
    word_cur     = word_r;
    phase_nxt    = phase_r;
    fault_nxt    = fault_r;

    if (c == CH_LPAREN) begin
      if (depth_r == DEPTH_W'(MAX_DEPTH)) begin
        fault_nxt = 1'b1;
      end else begin
        depth_nxt = depth_r + DEPTH_W'(1);
      end
    end else if (c == CH_RPAREN) begin
      if (depth_r == '0) begin
        fault_nxt = 1'b1;
      end else begin
        depth_nxt = depth_r - DEPTH_W'(1);
      end
    end

    if (op && prev_op_r) begin
      fault_nxt = 1'b1;
    end

    if (alpha) begin
      if (word_len_r < 3'd4) begin
        word_wr                      = 1'b1;
        word_cur[word_len_r[1:0]]    = c;
        word_len_nxt                 = word_len_r + 3'd1;
      end else begin
        word_len_nxt = 3'd5;
      end
    end else if (word_len_r != 3'd0) begin
      if (!word_ok(word_r, word_len_r, 1'b1, c)) begin
        fault_nxt = 1'b1;
      end
      word_len_nxt = 3'd0;
    end

    if (digit) begin
      if (phase_r == NUM_OUTSIDE) begin
        phase_nxt = NUM_INT;
      end else if (phase_r == NUM_POINT) begin
        phase_nxt = NUM_FRAC;
      end
    end else if (c == CH_POINT) begin
      if (phase_r == NUM_INT) begin
        phase_nxt = NUM_POINT;
      end else begin
        fault_nxt = 1'b1;
        phase_nxt = NUM_OUTSIDE;
      end
    end else begin
      if (phase_r == NUM_POINT) begin
        fault_nxt = 1'b1;
      end
      phase_nxt = NUM_OUTSIDE;
    end

    // End-of-expression checks look at the state as this character leaves it,
    // including a letter written by this very character.
    final_fault = fault_nxt || op || (depth_nxt != '0) || (phase_nxt == NUM_POINT) ||
                  ((word_len_nxt != 3'd0) &&
                   !word_ok(word_cur, word_len_nxt, 1'b0, CH_NUL));

    out_valid_nxt = out_valid_r && !out_ready;
    verdict_nxt   = verdict_r;
    if (item_take && item.last_char) begin
      out_valid_nxt = 1'b1;
      verdict_nxt   = final_fault;
      depth_nxt     = '0;
      prev_op_nxt   = 1'b0;
      word_len_nxt  = 3'd0;
      phase_nxt     = NUM_OUTSIDE;
      fault_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      prev_op_r   <= 1'b0;
      word_len_r  <= 3'd0;
      phase_r     <= NUM_OUTSIDE;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      verdict_r   <= 1'b0;
    end else begin
      if (item_take) begin
        depth_r    <= depth_nxt;
        prev_op_r  <= prev_op_nxt;
        word_len_r <= word_len_nxt;
        phase_r    <= phase_nxt;
        fault_r    <= fault_nxt;
      end
      out_valid_r <= out_valid_nxt;
      verdict_r   <= verdict_nxt;
    end
  end

  // Letter storage needs no reset: only entries below the run length are read.
  always_ff @(posedge clk) begin
    if (item_take && word_wr) begin
      word_r[word_len_r[1:0]] <= c;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

`default_nettype wire

/* src/calc_expression_syntax_check.sv */
// The last character passes the input register; its verdict is then held in the result register.
// Throughput: one character per cycle; the input register and the result
// register let a character enter while a verdict still waits to be taken.
// Only the last character of an expression waits, when the result register
// is still full. Synchronous active-low reset clears all checking state but the letter storage.
// ----------------------------------------------------------------------------
// calc_expression_syntax_check: calculator expression syntax checker
// Checks parentheses, operator placement, function names and number format
// of a character stream and gives one verdict per expression.
// ----------------------------------------------------------------------------
`default_nettype none

module calc_expression_syntax_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_last_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_verdict
);
  import cesc_pkg::*;

  cesc_item_t in_item;
  cesc_item_t item;
  logic       item_valid;
  logic       item_take;

  assign in_item.char_code = in_char_code;
  assign in_item.last_char = in_last_char;

  cesc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  cesc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item        (item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict)
  );

endmodule

`default_nettype wire
